>>> src/isv_pkg.sv
// ============================================================================
// isv_pkg
// Shared types, constants and helpers for the isotropic scatter velocity
// pipeline: CORDIC table, fixed-point formats, sideband structs.
// ============================================================================
`default_nettype none

package isv_pkg;

	// CORDIC
	localparam int ITER_COUNT_DEF = 24;
	localparam int CORDIC_MAX     = 32;
	localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

	localparam logic [31:0] ATAN_Q30 [CORDIC_MAX] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// 2*pi with 30 fraction bits (unsigned Q3.30), pi taken to seven decimals
	localparam logic [32:0] TWO_PI_Q30 = 33'((64'd31415926 << 31) / 64'd10000000);

	// Q2.30 unit values and mass ratio reset
	localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
	localparam logic signed [31:0] Q30_NEG_ONE = -32'sh4000_0000;
	localparam logic [23:0]        MR_RESET    = 24'd9138;

	// square root and divider shapes
	localparam int SQ_IN_W  = 64;
	localparam int DIV_NUM_W = 32;
	localparam int DIV_FRAC  = 30;
	localparam int DIV_Q_W   = 31;

	// azimuth quadrant from the top two bits of the phi fraction
	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	// sideband through the square root stages
	typedef struct packed {
		logic [31:0]        spd;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic signed [31:0] ct;
		quad_t              quad;
		logic [2:0][31:0]   pabs;
		logic [2:0]         pneg;
	} sq_side_t;

	// sideband through the divider stages
	typedef struct packed {
		logic [31:0]        spd;
		logic [24:0]        f;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic signed [31:0] ct;
		quad_t              quad;
		logic [30:0]        st;
		logic signed [33:0] ca;
		logic signed [33:0] sa;
		logic [2:0]         pneg;
	} dv_side_t;

	// magnitude of a 33-bit signed value
	function automatic logic [31:0] abs33(input logic signed [32:0] v);
		abs33 = v[32] ? 32'(-v) : 32'(v);
	endfunction

	// Q2.30 product, truncated toward zero
	function automatic logic signed [35:0] mulq(input logic signed [33:0] a,
		input logic signed [33:0] b);
		logic [33:0] aa;
		logic [33:0] bb;
		logic [67:0] pr;
		logic [35:0] m;
		aa = a[33] ? 34'(-a) : 34'(a);
		bb = b[33] ? 34'(-b) : 34'(b);
		pr = 68'(aa) * 68'(bb);
		m  = pr[65:30];
		mulq = (a[33] ^ b[33]) ? -$signed(m) : $signed(m);
	endfunction

endpackage

`default_nettype wire

>>> src/isotropic_scatter_velocity.sv
// ============================================================================
// isotropic_scatter_velocity
// Isotropic scatter of one particle per request: polar and azimuth angles
// from two uniform fractions, energy loss from the mass ratio, rotation of
// the new direction into a frame around the incoming direction.
// ============================================================================
// Usage:
//   A request is taken at each rising edge with start high and busy low.
//   busy stays low: the pipeline takes one request every cycle.
//   Each request yields one result; done is high for one cycle with
//   vel_x, vel_y, vel_z valid in that same cycle. The receiver cannot
//   hold results off, and none is needed: results leave in request order.
//   The path runs through three input stages, the 32-stage square root
//   (frame length, sin theta and speed factor side by side, CORDIC in
//   parallel), the 31-stage normalizing divider and four output stages.
//   mass_ratio is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
//   is always high. Write it only with no request in flight.
//   Reset clears all valid bits and sets mass_ratio to its default.
// ============================================================================
`default_nettype none

module isotropic_scatter_velocity #(
	parameter int ITER_COUNT = isv_pkg::ITER_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        speed,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic [23:0]        rand_theta,
	input  logic [23:0]        rand_phi,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        cfg_data,
	output logic               done,
	output logic signed [32:0] vel_x,
	output logic signed [32:0] vel_y,
	output logic signed [32:0] vel_z
);

	import isv_pkg::*;

	localparam int NC = (ITER_COUNT > CORDIC_MAX) ? CORDIC_MAX : ITER_COUNT;
	localparam logic signed [37:0] T_MAX = 38'sh0_8000_0000;
	localparam logic signed [37:0] T_MIN = -38'sh0_8000_0000;

	// mass ratio register
	logic [23:0] mr_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mr_q <= MR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mr_q <= cfg_data;
		end
	end

	// stage 1: capture request
	logic               vld_s1;
	logic [31:0]        spd_s1;
	logic signed [31:0] ux_s1, uy_s1, uz_s1;
	logic [23:0]        rt_s1, rp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		spd_s1 <= speed;
		ux_s1  <= dir_x;
		uy_s1  <= dir_y;
		uz_s1  <= dir_z;
		rt_s1  <= rand_theta;
		rp_s1  <= rand_phi;
	end

	// stage 2: cos theta, frame axis select, products
	logic signed [32:0] ct_c;
	logic [30:0]        ct_abs;
	logic               pole;
	logic signed [32:0] pxc, pyc, pzc;
	logic [2:0][31:0]   pabs_c;

	logic               vld_s2;
	logic [31:0]        spd_s2;
	logic signed [31:0] ux_s2, uy_s2, uz_s2, ct_s2;
	logic [61:0]        ctsq_s2;
	logic [49:0]        loss_s2;
	logic [30:0]        z0_s2;
	quad_t              quad_s2;
	logic [2:0][31:0]   pabs_s2;
	logic [2:0]         pneg_s2;
	logic [2:0][63:0]   sq_s2;

	always_comb begin
		ct_c   = 33'(Q30_ONE) - 33'({rt_s1, 7'b0});
		ct_abs = ct_c[32] ? 31'(-ct_c) : 31'(ct_c);
		pole   = (uz_s1 == Q30_ONE) || (uz_s1 == Q30_NEG_ONE) ||
		         (ux_s1 == '0 && uy_s1 == '0);
		pxc    = pole ? -33'(uz_s1) : 33'(uy_s1);
		pyc    = pole ? 33'sd0 : -33'(ux_s1);
		pzc    = pole ? 33'(ux_s1) : 33'sd0;
		pabs_c[0] = abs33(pxc);
		pabs_c[1] = abs33(pyc);
		pabs_c[2] = abs33(pzc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		spd_s2  <= spd_s1;
		ux_s2   <= ux_s1;
		uy_s2   <= uy_s1;
		uz_s2   <= uz_s1;
		ct_s2   <= 32'(ct_c);
		ctsq_s2 <= 62'(ct_abs) * 62'(ct_abs);
		loss_s2 <= {48'(mr_q) * 48'(rt_s1), 2'b00};
		z0_s2   <= 31'((55'(rp_s1[21:0]) * 55'(TWO_PI_Q30)) >> 24);
		quad_s2 <= quad_t'(rp_s1[23:22]);
		pabs_s2 <= pabs_c;
		pneg_s2 <= {pzc[32], pyc[32], pxc[32]};
		for (int l = 0; l < 3; l++) begin
			sq_s2[l] <= 64'(pabs_c[l]) * 64'(pabs_c[l]);
		end
	end

	// stage 3: radicands
	logic             vld_s3;
	logic [2:0][63:0] rad_s3;
	logic [30:0]      z0_s3;
	sq_side_t         sqs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rad_s3[0] <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		rad_s3[1] <= (64'd1 << 60) - 64'(ctsq_s2);
		rad_s3[2] <= (loss_s2 >= (50'd1 << 48)) ? 64'd0 : (64'd1 << 48) - 64'(loss_s2);
		z0_s3       <= z0_s2;
		sqs_s3.spd  <= spd_s2;
		sqs_s3.ux   <= ux_s2;
		sqs_s3.uy   <= uy_s2;
		sqs_s3.uz   <= uz_s2;
		sqs_s3.ct   <= ct_s2;
		sqs_s3.quad <= quad_s2;
		sqs_s3.pabs <= pabs_s2;
		sqs_s3.pneg <= pneg_s2;
	end

	// frame length, sin theta and speed factor
	logic             sq_vld;
	logic [2:0][31:0] sq_root;
	sq_side_t         sqs_out;

	isv_sqrt #(
		.IN_W   (SQ_IN_W),
		.LANES  (3),
		.SIDE_W ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.rad       (rad_s3),
		.side_in   (sqs_s3),
		.out_valid (sq_vld),
		.root      (sq_root),
		.side_out  (sqs_out)
	);

	// CORDIC for the azimuth, padded to the square root latency
	logic signed [33:0] cx_s [CORDIC_MAX];
	logic signed [33:0] cy_s [CORDIC_MAX];
	logic signed [33:0] cz_s [CORDIC_MAX];

	genvar i;
	generate
		for (i = 0; i < CORDIC_MAX; i++) begin : g_cordic
			localparam logic signed [33:0] ANG = 34'(ATAN_Q30[i]);
			logic signed [33:0] x_in, y_in, z_in;

			if (i == 0) begin : g_first
				assign x_in = CORDIC_KINV;
				assign y_in = 34'sd0;
				assign z_in = 34'(z0_s3);
			end else begin : g_next
				assign x_in = cx_s[i-1];
				assign y_in = cy_s[i-1];
				assign z_in = cz_s[i-1];
			end

			if (i < NC) begin : g_rot
				always_ff @(posedge clk) begin
					if (!z_in[33]) begin
						cx_s[i] <= x_in - (y_in >>> i);
						cy_s[i] <= y_in + (x_in >>> i);
						cz_s[i] <= z_in - ANG;
					end else begin
						cx_s[i] <= x_in + (y_in >>> i);
						cy_s[i] <= y_in - (x_in >>> i);
						cz_s[i] <= z_in + ANG;
					end
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					cx_s[i] <= x_in;
					cy_s[i] <= y_in;
					cz_s[i] <= z_in;
				end
			end
		end
	endgenerate

	// normalize the perpendicular axis
	dv_side_t         dvs_in;
	logic             dv_vld;
	logic [2:0][30:0] dv_q;
	dv_side_t         dvs_out;

	always_comb begin
		dvs_in.spd  = sqs_out.spd;
		dvs_in.f    = sq_root[2][24:0];
		dvs_in.ux   = sqs_out.ux;
		dvs_in.uy   = sqs_out.uy;
		dvs_in.uz   = sqs_out.uz;
		dvs_in.ct   = sqs_out.ct;
		dvs_in.quad = sqs_out.quad;
		dvs_in.st   = sq_root[1][30:0];
		dvs_in.ca   = cx_s[CORDIC_MAX-1];
		dvs_in.sa   = cy_s[CORDIC_MAX-1];
		dvs_in.pneg = sqs_out.pneg;
	end

	isv_div #(
		.LANES  (3),
		.SIDE_W ($bits(dv_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_vld),
		.num       (sqs_out.pabs),
		.den       (sq_root[0]),
		.side_in   (dvs_in),
		.out_valid (dv_vld),
		.quo       (dv_q),
		.side_out  (dvs_out)
	);

	// stage 4: signed axis, cross terms, angle products, reduced speed
	logic signed [31:0] pxn, pyn, pzn;
	logic signed [33:0] cp_c, sp_c;

	logic               vld_s4;
	logic signed [31:0] px_s4, py_s4, pz_s4, ux_s4, uy_s4, uz_s4, ct_s4;
	logic signed [35:0] pyuz_s4, pzuy_s4, pzux_s4, pxuz_s4, pxuy_s4, pyux_s4;
	logic signed [35:0] sc_s4, ss_s4;
	logic [31:0]        ve_s4;
	logic [56:0]        vprod;

	always_comb begin
		pxn = dvs_out.pneg[0] ? -32'(dv_q[0]) : 32'(dv_q[0]);
		pyn = dvs_out.pneg[1] ? -32'(dv_q[1]) : 32'(dv_q[1]);
		pzn = dvs_out.pneg[2] ? -32'(dv_q[2]) : 32'(dv_q[2]);
		case (dvs_out.quad)
			QUAD_0: begin
				cp_c = dvs_out.ca;
				sp_c = dvs_out.sa;
			end
			QUAD_1: begin
				cp_c = -dvs_out.sa;
				sp_c = dvs_out.ca;
			end
			QUAD_2: begin
				cp_c = -dvs_out.ca;
				sp_c = -dvs_out.sa;
			end
			QUAD_3: begin
				cp_c = dvs_out.sa;
				sp_c = -dvs_out.ca;
			end
			default: begin
				cp_c = dvs_out.ca;
				sp_c = dvs_out.sa;
			end
		endcase
		vprod = 57'(dvs_out.spd) * 57'(dvs_out.f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		px_s4   <= pxn;
		py_s4   <= pyn;
		pz_s4   <= pzn;
		ux_s4   <= dvs_out.ux;
		uy_s4   <= dvs_out.uy;
		uz_s4   <= dvs_out.uz;
		ct_s4   <= dvs_out.ct;
		pyuz_s4 <= mulq(34'(pyn), 34'(dvs_out.uz));
		pzuy_s4 <= mulq(34'(pzn), 34'(dvs_out.uy));
		pzux_s4 <= mulq(34'(pzn), 34'(dvs_out.ux));
		pxuz_s4 <= mulq(34'(pxn), 34'(dvs_out.uz));
		pxuy_s4 <= mulq(34'(pxn), 34'(dvs_out.uy));
		pyux_s4 <= mulq(34'(pyn), 34'(dvs_out.ux));
		sc_s4   <= mulq(34'(dvs_out.st), cp_c);
		ss_s4   <= mulq(34'(dvs_out.st), sp_c);
		ve_s4   <= vprod[55:24];
	end

	// stage 5: second axis and the three terms of each component
	logic signed [35:0] qx_c, qy_c, qz_c;
	logic               vld_s5;
	logic signed [35:0] qsc_s5 [3];
	logic signed [35:0] pss_s5 [3];
	logic signed [35:0] uct_s5 [3];
	logic [31:0]        ve_s5;

	always_comb begin
		qx_c = pyuz_s4 - pzuy_s4;
		qy_c = pzux_s4 - pxuz_s4;
		qz_c = pxuy_s4 - pyux_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		qsc_s5[0] <= mulq(34'(qx_c), 34'(sc_s4));
		qsc_s5[1] <= mulq(34'(qy_c), 34'(sc_s4));
		qsc_s5[2] <= mulq(34'(qz_c), 34'(sc_s4));
		pss_s5[0] <= mulq(34'(px_s4), 34'(ss_s4));
		pss_s5[1] <= mulq(34'(py_s4), 34'(ss_s4));
		pss_s5[2] <= mulq(34'(pz_s4), 34'(ss_s4));
		uct_s5[0] <= mulq(34'(ux_s4), 34'(ct_s4));
		uct_s5[1] <= mulq(34'(uy_s4), 34'(ct_s4));
		uct_s5[2] <= mulq(34'(uz_s4), 34'(ct_s4));
		ve_s5     <= ve_s4;
	end

	// stage 6: component sums clamped to +-2.0
	logic signed [37:0] tsum [3];
	logic               vld_s6;
	logic signed [32:0] t_s6 [3];
	logic [31:0]        ve_s6;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			tsum[l] = 38'(qsc_s5[l]) + 38'(pss_s5[l]) + 38'(uct_s5[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (tsum[l] > T_MAX) begin
				t_s6[l] <= 33'(T_MAX);
			end else if (tsum[l] < T_MIN) begin
				t_s6[l] <= 33'(T_MIN);
			end else begin
				t_s6[l] <= 33'(tsum[l]);
			end
		end
		ve_s6 <= ve_s5;
	end

	// stage 7: scale by reduced speed, saturate, output register
	logic [31:0]        tabs [3];
	logic [63:0]        sprod [3];
	logic [31:0]        pv [3];
	logic               vld_s7;
	logic signed [32:0] vel_s7 [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			tabs[l]  = t_s6[l][32] ? 32'(-t_s6[l]) : 32'(t_s6[l]);
			sprod[l] = 64'(ve_s6) * 64'(tabs[l]);
			pv[l]    = (sprod[l][63:62] != 2'b00) ? 32'hFFFF_FFFF : sprod[l][61:30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			vel_s7[l] <= t_s6[l][32] ? -$signed({1'b0, pv[l]}) : $signed({1'b0, pv[l]});
		end
	end

	assign done  = vld_s7;
	assign vel_x = vel_s7[0];
	assign vel_y = vel_s7[1];
	assign vel_z = vel_s7[2];

endmodule

`default_nettype wire

>>> src/isv_sqrt.sv
// ============================================================================
// isv_sqrt
// Pipelined integer square root, several lanes in lockstep, one result bit
// per stage, with a sideband that travels alongside.
// ============================================================================
`default_nettype none

module isv_sqrt #(
	parameter int IN_W   = isv_pkg::SQ_IN_W,
	parameter int LANES  = 3,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [LANES-1:0][IN_W-1:0]       rad,
	input  logic [SIDE_W-1:0]                side_in,
	output logic                             out_valid,
	output logic [LANES-1:0][IN_W/2-1:0]     root,
	output logic [SIDE_W-1:0]                side_out
);

	localparam int OUT_W = IN_W / 2;

	logic                         vld_s  [OUT_W];
	logic [LANES-1:0][IN_W-1:0]   rem_s  [OUT_W];
	logic [LANES-1:0][IN_W-1:0]   acc_s  [OUT_W];
	logic [SIDE_W-1:0]            side_s [OUT_W];

	genvar k;
	generate
		for (k = 0; k < OUT_W; k++) begin : g_stage
			localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (2 * (OUT_W - 1 - k));
			logic                       vld_in;
			logic [LANES-1:0][IN_W-1:0] rem_in;
			logic [LANES-1:0][IN_W-1:0] acc_in;
			logic [SIDE_W-1:0]          side_i;
			logic [LANES-1:0][IN_W-1:0] trial;

			if (k == 0) begin : g_first
				assign vld_in = in_valid;
				assign rem_in = rad;
				assign acc_in = '0;
				assign side_i = side_in;
			end else begin : g_next
				assign vld_in = vld_s[k-1];
				assign rem_in = rem_s[k-1];
				assign acc_in = acc_s[k-1];
				assign side_i = side_s[k-1];
			end

			// trial subtrahend per lane
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					trial[l] = acc_in[l] + BIT;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_in;
				end
			end

			// one root bit per lane
			always_ff @(posedge clk) begin
				for (int l = 0; l < LANES; l++) begin
					if (rem_in[l] >= trial[l]) begin
						rem_s[k][l] <= rem_in[l] - trial[l];
						acc_s[k][l] <= (acc_in[l] >> 1) + BIT;
					end else begin
						rem_s[k][l] <= rem_in[l];
						acc_s[k][l] <= acc_in[l] >> 1;
					end
				end
				side_s[k] <= side_i;
			end
		end
	endgenerate

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			root[l] = acc_s[OUT_W-1][l][OUT_W-1:0];
		end
	end

	assign out_valid = vld_s[OUT_W-1];
	assign side_out  = side_s[OUT_W-1];

endmodule

`default_nettype wire

>>> src/isv_div.sv
// ============================================================================
// isv_div
// Pipelined restoring divider: several numerators over one shared divisor,
// quotient in unsigned Q1.30, one quotient bit per stage. A zero divisor gives zero.
// ============================================================================
`default_nettype none

module isv_div #(
	parameter int LANES  = 3,
	parameter int SIDE_W = 1
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	input  logic [LANES-1:0][isv_pkg::DIV_NUM_W-1:0]  num,
	input  logic [isv_pkg::DIV_NUM_W-1:0]             den,
	input  logic [SIDE_W-1:0]                         side_in,
	output logic                                      out_valid,
	output logic [LANES-1:0][isv_pkg::DIV_Q_W-1:0]    quo,
	output logic [SIDE_W-1:0]                         side_out
);

	import isv_pkg::*;

	localparam int RW = DIV_NUM_W + DIV_FRAC;

	logic                          vld_s  [DIV_Q_W];
	logic [LANES-1:0][RW-1:0]      rem_s  [DIV_Q_W];
	logic [LANES-1:0][DIV_Q_W-1:0] q_s    [DIV_Q_W];
	logic [DIV_NUM_W-1:0]          den_s  [DIV_Q_W];
	logic [SIDE_W-1:0]             side_s [DIV_Q_W];

	genvar k;
	generate
		for (k = 0; k < DIV_Q_W; k++) begin : g_stage
			localparam int J = DIV_Q_W - 1 - k;
			logic                          vld_in;
			logic [LANES-1:0][RW-1:0]      rem_in;
			logic [LANES-1:0][DIV_Q_W-1:0] q_in;
			logic [DIV_NUM_W-1:0]          den_in;
			logic [SIDE_W-1:0]             side_i;
			logic [RW:0]                   dsh;

			if (k == 0) begin : g_first
				always_comb begin
					for (int l = 0; l < LANES; l++) begin
						rem_in[l] = {num[l], {DIV_FRAC{1'b0}}};
					end
				end
				assign vld_in = in_valid;
				assign q_in   = '0;
				assign den_in = den;
				assign side_i = side_in;
			end else begin : g_next
				assign vld_in = vld_s[k-1];
				assign rem_in = rem_s[k-1];
				assign q_in   = q_s[k-1];
				assign den_in = den_s[k-1];
				assign side_i = side_s[k-1];
			end

			// shifted divisor for this quotient bit
			assign dsh = (RW + 1)'(den_in) << J;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				for (int l = 0; l < LANES; l++) begin
					if ({1'b0, rem_in[l]} >= dsh) begin
						rem_s[k][l] <= rem_in[l] - dsh[RW-1:0];
						q_s[k][l]   <= {q_in[l][DIV_Q_W-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= rem_in[l];
						q_s[k][l]   <= {q_in[l][DIV_Q_W-2:0], 1'b0};
					end
				end
				den_s[k]  <= den_in;
				side_s[k] <= side_i;
			end
		end
	endgenerate

	assign out_valid = vld_s[DIV_Q_W-1];
	assign quo       = (den_s[DIV_Q_W-1] == '0) ? '0 : q_s[DIV_Q_W-1];
	assign side_out  = side_s[DIV_Q_W-1];

endmodule

`default_nettype wire
